// ===== src/wmcs_pkg.sv =====
// shared types and constants for the windowed max chain sum block
`timescale 1ns / 1ps
package wmcs_pkg;

  localparam int VAL_W = 48;
  localparam int WIN_W = 11;
  localparam int IN_W  = 32;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);

  typedef struct packed {
    logic signed [VAL_W-1:0] best_so_far;
    logic signed [VAL_W-1:0] chain_value;
  } res_t;

  typedef struct packed {
    logic                    valid;
    logic                    first_of_run;
    logic signed [VAL_W-1:0] sample;
  } item_t;

endpackage

// ===== src/wmcs_ram.sv =====
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
module wmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/wmcs_ctrl.sv =====
// monotonic deque in ram: binary search for the window max, then head expiry check, pop and push
`timescale 1ns / 1ps
module wmcs_ctrl #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [wmcs_pkg::WIN_W-1:0] window,
  input  wmcs_pkg::item_t          item,
  output logic                     idle,
  output logic                     res_valid,
  input  logic                     res_take,
  output wmcs_pkg::res_t           res
);
  import wmcs_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int EW   = CW + VAL_W;
  localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;
  localparam logic [CW:0]   MAXV  = (CW + 1)'(MAX_WINDOW);
  localparam logic [AW-1:0] LASTA = AW'(MAX_WINDOW - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SRCH_RD = 10'b0000000010,
    S_SRCH_WT = 10'b0000000100,
    S_CALC    = 10'b0000001000,
    S_DROP_RD = 10'b0000010000,
    S_DROP_WT = 10'b0000100000,
    S_POP_RD  = 10'b0001000000,
    S_POP_WT  = 10'b0010000000,
    S_PUSH    = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] head, tail;
  logic [CW-1:0] count, lo, hi, mid, seq;
  logic          run_open;
  logic signed [VAL_W-1:0] s_val, cand, chain, best;
  logic          start;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic [CW-1:0] rd_seq, rd_age;
  logic signed [VAL_W-1:0] rd_val;

  logic [CW:0]   mid_sum, addr_sum;
  logic [CW-1:0] mid_w;
  logic [AW-1:0] mid_addr, head_inc, tail_inc, tail_dec;
  logic          in_win;
  logic signed [VAL_W:0] sum_w;
  logic signed [VAL_W-1:0] link, chain_w;

  wmcs_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_seq = rd_data[EW-1:VAL_W];
  assign rd_val = $signed(rd_data[VAL_W-1:0]);
  assign rd_age = seq - rd_seq;
  assign in_win = CMPW'(rd_age) <= CMPW'(window);

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_w    = mid_sum[CW:1];
  assign addr_sum = (CW + 1)'(head) + (CW + 1)'(mid_w);
  assign mid_addr = (addr_sum >= MAXV) ? AW'(addr_sum - MAXV) : AW'(addr_sum);
  assign head_inc = (head == LASTA) ? '0 : head + AW'(1);
  assign tail_inc = (tail == LASTA) ? '0 : tail + AW'(1);
  assign tail_dec = (tail == '0) ? LASTA : tail - AW'(1);

  // link is never below zero, then a saturating add
  assign link    = (cand > 0) ? cand : '0;
  assign sum_w   = {s_val[VAL_W-1], s_val} + {link[VAL_W-1], link};
  assign chain_w = (sum_w[VAL_W] != sum_w[VAL_W-1]) ?
                   (sum_w[VAL_W] ? VAL_MIN : VAL_MAX) : sum_w[VAL_W-1:0];

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.chain_value = chain;
  assign res.best_so_far = best;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_addr;
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = {seq, chain};
    unique case (state)
      S_SRCH_RD: begin
        rd_en = 1'b1;
      end
      S_DROP_RD: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      S_POP_RD: begin
        rd_en   = 1'b1;
        rd_addr = tail_dec;
      end
      S_PUSH: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_SRCH_RD;
          if (item.first_of_run || !run_open || count == '0) state_next = S_CALC;
        end
      end
      S_SRCH_RD: state_next = S_SRCH_WT;
      S_SRCH_WT: begin
        if (in_win) state_next = (lo < mid) ? S_SRCH_RD : S_CALC;
        else state_next = ((mid + CW'(1)) < hi) ? S_SRCH_RD : S_CALC;
      end
      S_CALC:    state_next = (count != '0) ? S_DROP_RD : S_PUSH;
      S_DROP_RD: state_next = S_DROP_WT;
      S_DROP_WT: begin
        if (rd_age >= CW'(MAX_WINDOW)) state_next = (count > CW'(1)) ? S_POP_RD : S_PUSH;
        else state_next = S_POP_RD;
      end
      S_POP_RD:  state_next = S_POP_WT;
      S_POP_WT: begin
        if (rd_val <= chain && count > CW'(1)) state_next = S_POP_RD;
        else state_next = S_PUSH;
      end
      S_PUSH:    state_next = S_DONE;
      S_DONE:    if (res_take) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      seq      <= '0;
      run_open <= 1'b0;
      best     <= '0;
      start    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            s_val <= item.sample;
            cand  <= '0;
            lo    <= '0;
            start <= item.first_of_run || !run_open;
            if (item.first_of_run || !run_open) begin
              head  <= '0;
              tail  <= '0;
              count <= '0;
              hi    <= '0;
            end else begin
              hi <= count;
            end
          end
        end
        S_SRCH_RD: mid <= mid_w;
        S_SRCH_WT: begin
          if (in_win) begin
            hi   <= mid;
            cand <= rd_val;
          end else begin
            lo <= mid + CW'(1);
          end
        end
        S_CALC: chain <= chain_w;
        S_DROP_WT: begin
          if (rd_age >= CW'(MAX_WINDOW)) begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
        end
        S_POP_WT: begin
          if (rd_val <= chain) begin
            tail  <= tail_dec;
            count <= count - CW'(1);
          end
        end
        S_PUSH: begin
          tail     <= tail_inc;
          count    <= count + CW'(1);
          seq      <= seq + CW'(1);
          run_open <= 1'b1;
          if (start || chain > best) best <= chain;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/windowed_max_chain_sum.sv =====
// top level: stream ports, window register, output register, deque engine
`timescale 1ns / 1ps
// per sample: a binary search of about log2(n+1) steps, n = deque entries of the run,
//   a check of the head entry for expiry, pops, then a push; a run start goes to the push
// throughput: one sample at a time; the registered ram read port is shared by the
//   binary search, the head expiry check and the pop loop
// reset: synchronous active high rst clears the deque, run flag, best value
//   and output valid; window returns to 1; ram contents are not cleared
module windowed_max_chain_sum #(
  parameter int MAX_WINDOW   = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tuser,   // [0] first_of_run
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [47:0] chain_value, [95:48] best_so_far
  // window register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data        // [10:0] window
);
  import wmcs_pkg::*;

  localparam int SHIFT = VAL_W - SAMPLE_WIDTH;

  logic [WIN_W-1:0] window;
  item_t            item;
  logic             eng_idle, res_valid, res_take;
  res_t             res, out_res;
  logic [VAL_W-1:0] raw;

  // config writes always land at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window <= cfg_data;
    end
  end

  // sign extend from SAMPLE_WIDTH bits of the field
  assign raw = {{(VAL_W - IN_W){1'b0}}, s_axis_tdata};
  assign item.sample = $signed(raw << SHIFT) >>> SHIFT;
  assign item.first_of_run = s_axis_tuser;
  assign item.valid = s_axis_tvalid && eng_idle;

  assign s_axis_tready = eng_idle;

  wmcs_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .item      (item),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register frees the engine while a result waits for transfer
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.best_so_far, out_res.chain_value};

endmodule

// ===== src/wmcs_checker.sv =====
// port level checks for the windowed max chain sum block
`timescale 1ns / 1ps
module wmcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // no result after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // best of the run never trails this chain value
  a_best: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[95:48]) >= $signed(m_axis_tdata[47:0]))
    else $error("best_so_far below chain_value");

  // one sample in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind windowed_max_chain_sum wmcs_checker u_wmcs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
